// File: src/lpht_pkg.sv
package lpht_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_FOUND    = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } slot_mark_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_MIX,
    S_MOD,
    S_PROBE,
    S_WIPE
  } fsm_e;

  typedef struct packed {
    slot_mark_e  mark;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  localparam logic [31:0] HASH_XOR = 32'd61;
  localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;

  // front half of the integer mix, everything before the multiply
  function automatic logic [31:0] mix_front(input logic [31:0] k);
    logic [31:0] h0;
    logic [31:0] h1;
    h0 = (k ^ HASH_XOR) ^ (k >> 16);
    h1 = h0 + (h0 << 3);
    return h1 ^ (h1 >> 4);
  endfunction

endpackage

// File: src/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing.
// Request channel: action_i, key_i, new_value_i are taken at a rising edge where
// start is high and busy is low. Every request gives exactly one result on
// success_o, status_o, found_value_o, live_entries_o and tombstones_o, valid
// for the single cycle in which done_o is high; the receiver cannot stall it.
// Slots live in one synchronous memory (mark, key, value) with a registered read.
// Insert/remove/find: a hash multiply step, a mix and home read step, then one
// probed slot per cycle; busy stays high through these and the result strobe
// follows, so no new request is taken before that strobe. When TABLE_SLOTS is not
// a power of two the home slot is reduced by a reciprocal multiply, a back
// multiply, a subtract and one correction before the probe walk. The probe walk
// sets the rate: one slot a cycle.
// Clear sweeps every slot, one per cycle, then gives its result.
// A new request may be taken in the same cycle that done_o shows a result.
// After reset the same sweep runs once (busy high, no result).
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] new_value_i,
  output logic        done_o,
  output logic        success_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o,
  output logic [8:0]  live_entries_o,
  output logic [8:0]  tombstones_o
);

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam bit          POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam logic [31:0] NSZ   = 32'(TABLE_SLOTS);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));

  fsm_e        state_q, state_d;
  action_e     act_q, act_d;
  logic [31:0] key_q, key_d;
  logic [31:0] val_q, val_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] div_q, div_d;
  logic [1:0]  step_q, step_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] probe_q, probe_d;
  logic [CW-1:0] entry_q, entry_d;
  logic [CW-1:0] tomb_q, tomb_d;
  logic        wipe_req_q, wipe_req_d;
  logic        done_q, done_d;
  logic        success_q, success_d;
  status_e     status_q, status_d;
  logic [31:0] fv_q, fv_d;

  slot_t       mem [TABLE_SLOTS];
  slot_t       rd_q;
  logic        we;
  slot_t       wdata;

  logic          accept;
  logic [31:0]   mixed;
  logic [63:0]   recip_prod;
  logic [31:0]   rem_fix;
  logic [IW-1:0] idx_inc;
  logic          idx_last, probe_last;
  logic          is_live, is_empty, key_eq;
  logic          probe_end;
  logic [CW+8:0] entry_ext, tomb_ext;

  assign accept     = start && !busy;
  assign mixed      = prod_q ^ (prod_q >> 15);
  assign recip_prod = 64'(div_q) * 64'(RECIP);
  assign rem_fix    = (div_q >= NSZ) ? div_q - NSZ : div_q;
  assign idx_last   = (idx_q == IW'(TABLE_SLOTS - 1));
  assign idx_inc    = idx_last ? '0 : idx_q + 1'b1;
  assign probe_last = (probe_q == IW'(TABLE_SLOTS - 1));

  assign is_live  = (rd_q.mark == MARK_LIVE);
  assign is_empty = (rd_q.mark == MARK_EMPTY);
  assign key_eq   = (rd_q.key == key_q);

  always_comb begin
    if (act_q == ACT_INSERT) begin
      probe_end = !is_live || key_eq || probe_last;
    end else begin
      probe_end = is_empty || (is_live && key_eq) || probe_last;
    end
  end

  // slot memory: one write port, one registered read port addressed by the next index
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[idx_d];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (action_e'(action_i) == ACT_CLEAR) ? S_WIPE : S_HASH;
        end
      end
      S_HASH:  state_d = S_MIX;
      S_MIX:   state_d = POW2 ? S_PROBE : S_MOD;
      S_MOD: begin
        if (step_q == 2'd3) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_end) begin
          state_d = S_IDLE;
        end
      end
      S_WIPE: begin
        if (idx_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    val_d      = val_q;
    prod_d     = prod_q;
    div_d      = div_q;
    step_d     = step_q;
    idx_d      = idx_q;
    probe_d    = probe_q;
    entry_d    = entry_q;
    tomb_d     = tomb_q;
    wipe_req_d = wipe_req_q;
    done_d     = 1'b0;
    success_d  = success_q;
    status_d   = status_q;
    fv_d       = fv_q;
    we         = 1'b0;
    wdata      = '{mark: MARK_EMPTY, key: '0, value: '0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d = action_e'(action_i);
          key_d = key_i;
          val_d = new_value_i;
          if (action_e'(action_i) == ACT_CLEAR) begin
            idx_d      = '0;
            wipe_req_d = 1'b1;
            entry_d    = '0;
            tomb_d     = '0;
          end
        end
      end
      S_HASH: begin
        prod_d = mix_front(key_q) * HASH_MUL;
      end
      S_MIX: begin
        probe_d = '0;
        if (POW2) begin
          idx_d = mixed[IW-1:0];
        end else begin
          div_d  = mixed;
          step_d = '0;
        end
      end
      S_MOD: begin
        // quotient estimate from the reciprocal is low by at most one
        step_d = step_q + 2'd1;
        unique case (step_q)
          2'd0:    prod_d = recip_prod[63:32];
          2'd1:    prod_d = prod_q * NSZ;
          2'd2:    div_d  = div_q - prod_q;
          default: idx_d  = rem_fix[IW-1:0];
        endcase
      end
      S_PROBE: begin
        if (!probe_end) begin
          idx_d   = idx_inc;
          probe_d = probe_q + 1'b1;
        end else begin
          done_d    = 1'b1;
          success_d = 1'b0;
          status_d  = ST_NOTFOUND;
          fv_d      = '0;
          if (act_q == ACT_INSERT) begin
            if (!is_live) begin
              we        = 1'b1;
              wdata     = '{mark: MARK_LIVE, key: key_q, value: val_q};
              entry_d   = entry_q + 1'b1;
              if (rd_q.mark == MARK_TOMB && tomb_q != '0) begin
                tomb_d = tomb_q - 1'b1;
              end
              success_d = 1'b1;
              status_d  = ST_INSERTED;
            end else if (key_eq) begin
              we        = 1'b1;
              wdata     = '{mark: MARK_LIVE, key: key_q, value: val_q};
              success_d = 1'b1;
              status_d  = ST_UPDATED;
            end else begin
              status_d  = ST_FULL;
            end
          end else if (is_live && key_eq) begin
            success_d = 1'b1;
            if (act_q == ACT_REMOVE) begin
              we       = 1'b1;
              wdata    = '{mark: MARK_TOMB, key: '0, value: '0};
              if (entry_q != '0) begin
                entry_d = entry_q - 1'b1;
              end
              tomb_d   = tomb_q + 1'b1;
              status_d = ST_REMOVED;
            end else begin
              fv_d     = rd_q.value;
              status_d = ST_FOUND;
            end
          end
        end
      end
      S_WIPE: begin
        we    = 1'b1;
        idx_d = idx_inc;
        if (idx_last) begin
          wipe_req_d = 1'b0;
          if (wipe_req_q) begin
            done_d    = 1'b1;
            success_d = 1'b1;
            status_d  = ST_CLEARED;
            fv_d      = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_WIPE;
      idx_q      <= '0;
      probe_q    <= '0;
      step_q     <= '0;
      entry_q    <= '0;
      tomb_q     <= '0;
      wipe_req_q <= 1'b0;
      done_q     <= 1'b0;
      act_q      <= ACT_INSERT;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      probe_q    <= probe_d;
      step_q     <= step_d;
      entry_q    <= entry_d;
      tomb_q     <= tomb_d;
      wipe_req_q <= wipe_req_d;
      done_q     <= done_d;
      act_q      <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    val_q     <= val_d;
    prod_q    <= prod_d;
    div_q     <= div_d;
    success_q <= success_d;
    status_q  <= status_d;
    fv_q      <= fv_d;
  end

  // counts settle by the edge that raises the result and hold through the strobe
  assign entry_ext = {9'd0, entry_q};
  assign tomb_ext  = {9'd0, tomb_q};

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign success_o      = success_q;
  assign status_o       = status_q;
  assign found_value_o  = fv_q;
  assign live_entries_o = entry_ext[8:0];
  assign tombstones_o   = tomb_ext[8:0];

endmodule

// File: src/lpht_checker.sv
module lpht_checker import lpht_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        success_o,
  input logic [2:0]  status_o,
  input logic [31:0] found_value_o
);

  // a result only appears once the table is free for the next request
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_success_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (success_o == (status_o != ST_NOTFOUND && status_o != ST_FULL)))
    else $error("success flag disagrees with status");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_FOUND) |-> (found_value_o == 32'd0))
    else $error("found value nonzero without a hit");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .success_o     (success_o),
  .status_o      (status_o),
  .found_value_o (found_value_o)
);
